[hw/rtl/hash_prng_range_draw_assert.svh]
// assertion helpers for hash_prng_range_draw
`ifndef HASH_PRNG_RANGE_DRAW_ASSERT_SVH
`define HASH_PRNG_RANGE_DRAW_ASSERT_SVH

// same-cycle implication
`define HPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/hpr_pkg.sv]
`default_nettype none

package hpr_pkg;

	localparam logic [31:0] WEYL_STEP = 32'he120fc15;
	localparam logic [31:0] MIX_MUL_A = 32'h4a39b70d;
	localparam logic [31:0] MIX_MUL_B = 32'h12fad5c9;

	localparam logic [1:0] REQ_SEED  = 2'd0;
	localparam logic [1:0] REQ_RAW   = 2'd1;
	localparam logic [1:0] REQ_RANGE = 2'd2;

	localparam logic [1:0] ST_VALID   = 2'd0;
	localparam logic [1:0] ST_SEEDED  = 2'd1;
	localparam logic [1:0] ST_BADSPAN = 2'd2;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		OP_SEED,
		OP_RAW,
		OP_RANGE,
		OP_BAD
	} op_t;

	// word: seed state for OP_SEED, range_min for OP_RANGE
	typedef struct packed {
		op_t         op;
		logic [31:0] word;
		logic [31:0] span;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MIX1,
		BK_MIX2,
		BK_FOLD,
		BK_DIV,
		BK_ADD,
		BK_DONE
	} bk_state_t;

	function automatic logic [31:0] fold64(input logic [63:0] p);
		return p[63:32] ^ p[31:0];
	endfunction

endpackage

`default_nettype wire

[hw/rtl/hash_prng_range_draw.sv]
// Counter-based 32-bit generator with a two-round multiply-fold mixer. Requests
// (seed, raw draw, ranged draw) are classified on entry and held in a two-deep
// queue, so the input can take up to two requests while the execution unit works
// and while a result waits at the output register. The execution unit handles one
// request at a time: a seed or a rejected request goes straight to the output
// register, a raw draw runs the Weyl add, two registered 32x32 products and fold,
// and a ranged draw adds the radix-2 restoring remainder unit for the modulo by
// the span and the add of range_min. A ranged draw with range_max <= range_min, or an
// unused request code, returns zero with the bad-span status and leaves the
// generator untouched.
`default_nettype none

module hash_prng_range_draw (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] seed_x,
	input  wire logic [15:0] seed_y,
	input  wire logic signed [31:0] range_min,
	input  wire logic signed [31:0] range_max,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      value,
	output logic [1:0]       status
);
	import hpr_pkg::*;

	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	hpr_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.seed_x     (seed_x),
		.seed_y     (seed_y),
		.range_min  (range_min),
		.range_max  (range_max),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	hpr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	hpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.status     (status)
	);

`include "hash_prng_range_draw_assert.svh"

	`HPR_ASSERT_NOW(a_zero_unless_valid, out_valid && (status != ST_VALID), value == '0, "non-zero value on seed or bad span")
	`HPR_ASSERT_NEXT(a_queue_holds_req, in_valid && in_ready, pop_valid, "accepted request missing from queue")
	`HPR_ASSERT_NOW(a_empty_span_rejected, push_valid && (req_type == REQ_RANGE) && (range_max <= range_min), push_job.op == OP_BAD, "empty span not rejected")

endmodule

`default_nettype wire

[hw/rtl/hpr_fifo.sv]
`default_nettype none

module hpr_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire hpr_pkg::job_t push_job,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output hpr_pkg::job_t      pop_job
);
	import hpr_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/hpr_front.sv]
`default_nettype none

module hpr_front (
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] seed_x,
	input  wire logic [15:0] seed_y,
	input  wire logic [31:0] range_min,
	input  wire logic [31:0] range_max,
	output logic             push_valid,
	input  wire logic        push_ready,
	output hpr_pkg::job_t    push_job
);
	import hpr_pkg::*;

	logic [32:0] diff;
	logic        span_ok;

	// exact signed difference, 33 bits
	assign diff    = {range_max[31], range_max} - {range_min[31], range_min};
	assign span_ok = !diff[32] && (diff != '0);

	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	always_comb begin
		push_job.span = diff[31:0];
		push_job.word = range_min;
		push_job.op   = OP_BAD;
		case (req_type)
			REQ_SEED: begin
				push_job.op   = OP_SEED;
				push_job.word = {seed_x, seed_y};
			end
			REQ_RAW: begin
				push_job.op = OP_RAW;
			end
			REQ_RANGE: begin
				push_job.op = span_ok ? OP_RANGE : OP_BAD;
			end
			default: begin
				push_job.op = OP_BAD;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/hpr_back.sv]
`default_nettype none

module hpr_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pop_valid,
	output logic             pop_ready,
	input  wire hpr_pkg::job_t pop_job,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      value,
	output logic [1:0]       status
);
	import hpr_pkg::*;

	bk_state_t            state_q;
	bk_state_t            state_nxt;
	logic [31:0]          gen_q;
	op_t                  op_q;
	logic [31:0]          base_q;
	logic [31:0]          span_q;
	logic [63:0]          prod_q;
	logic [31:0]          dvd_q;
	logic [31:0]          rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [31:0]          res_val_q;
	logic [1:0]           res_st_q;
	logic [31:0]          value_q;
	logic [1:0]           status_q;
	logic                 out_valid_q;
	logic                 out_free;
	logic                 div_last;
	logic [32:0]          trial;
	logic [32:0]          trial_sub;
	logic [31:0]          rem_nxt;

	assign out_free  = !out_valid_q || out_ready;
	assign div_last  = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign trial     = {rem_q, dvd_q[31]};
	assign trial_sub = trial - {1'b0, span_q};
	assign rem_nxt   = trial_sub[32] ? trial[31:0] : trial_sub[31:0];

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	always_comb begin
		state_nxt = state_q;
		pop_ready = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					case (pop_job.op)
						OP_RAW, OP_RANGE: state_nxt = BK_MIX1;
						default:          state_nxt = BK_DONE;
					endcase
				end
			end
			BK_MIX1: state_nxt = BK_MIX2;
			BK_MIX2: state_nxt = BK_FOLD;
			BK_FOLD: state_nxt = (op_q == OP_RANGE) ? BK_DIV : BK_DONE;
			BK_DIV:  state_nxt = div_last ? BK_ADD : BK_DIV;
			BK_ADD:  state_nxt = BK_DONE;
			BK_DONE: state_nxt = out_free ? BK_IDLE : BK_DONE;
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			gen_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == BK_IDLE && pop_valid) begin
				case (pop_job.op)
					OP_SEED:          gen_q <= pop_job.word;
					OP_RAW, OP_RANGE: gen_q <= gen_q + WEYL_STEP;
					default:          gen_q <= gen_q;
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == BK_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (pop_valid) begin
					op_q      <= pop_job.op;
					base_q    <= pop_job.word;
					span_q    <= pop_job.span;
					res_val_q <= '0;
					res_st_q  <= (pop_job.op == OP_SEED) ? ST_SEEDED : ST_BADSPAN;
				end
			end
			BK_MIX1: begin
				prod_q <= {32'd0, gen_q} * {32'd0, MIX_MUL_A};
			end
			BK_MIX2: begin
				prod_q <= {32'd0, fold64(prod_q)} * {32'd0, MIX_MUL_B};
			end
			BK_FOLD: begin
				res_val_q <= fold64(prod_q);
				res_st_q  <= ST_VALID;
				dvd_q     <= fold64(prod_q);
				rem_q     <= '0;
				cnt_q     <= '0;
			end
			BK_DIV: begin
				rem_q <= rem_nxt;
				dvd_q <= {dvd_q[30:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			BK_ADD: begin
				res_val_q <= rem_q + base_q;
			end
			BK_DONE: begin
				if (out_free) begin
					value_q  <= res_val_q;
					status_q <= res_st_q;
				end
			end
			default: begin
				res_val_q <= res_val_q;
			end
		endcase
	end

endmodule

`default_nettype wire

[tb/hash_prng_range_draw_tb.sv]
`timescale 1ns / 1ps

module hash_prng_range_draw_tb;
	import hpr_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int STALL_PCT = 29;
	localparam int RANDOM_ITEMS = 290;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AT = 100;
	localparam int SETTLE_CYCLES = 100;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [31:0] rmin;
		logic [31:0] rmax;
	} draw_req_t;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
	} draw_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] req_type = REQ_SEED;
	logic [15:0] seed_x = '0;
	logic [15:0] seed_y = '0;
	logic signed [31:0] range_min = '0;
	logic signed [31:0] range_max = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] value;
	logic [1:0] status;

	draw_req_t pending_reqs[$];
	draw_res_t expected_draws[$];
	draw_req_t cur_req;
	draw_res_t want;
	logic [31:0] gen_state = '0;
	int unsigned n_accepted = 0;
	int unsigned n_results = 0;
	int unsigned hold_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned errors = 0;

	hash_prng_range_draw u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.seed_x(seed_x),
		.seed_y(seed_y),
		.range_min(range_min),
		.range_max(range_max),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value),
		.status(status)
	);

	always #1 clk = ~clk;

	function automatic logic [31:0] mul_fold(input logic [31:0] a, input logic [31:0] k);
		logic [63:0] p;
		p = {32'd0, a} * {32'd0, k};
		return p[63:32] ^ p[31:0];
	endfunction

	function automatic logic [31:0] next_word();
		gen_state = gen_state + WEYL_STEP;
		return mul_fold(mul_fold(gen_state, MIX_MUL_A), MIX_MUL_B);
	endfunction

	function automatic draw_res_t predict_draw(input draw_req_t r);
		draw_res_t res;
		logic [31:0] span;
		res.value = '0;
		res.status = ST_BADSPAN;
		case (r.kind)
			REQ_SEED: begin
				gen_state = {r.sx, r.sy};
				res.status = ST_SEEDED;
			end
			REQ_RAW: begin
				res.value = next_word();
				res.status = ST_VALID;
			end
			REQ_RANGE: begin
				if ($signed(r.rmax) > $signed(r.rmin)) begin
					span = r.rmax - r.rmin;
					res.value = (next_word() % span) + r.rmin;
					res.status = ST_VALID;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic draw_req_t random_request();
		draw_req_t r;
		int unsigned pick;
		r.kind = REQ_RANGE;
		r.sx = 16'($urandom_range(16'hffff));
		r.sy = 16'($urandom_range(16'hffff));
		r.rmin = $urandom();
		r.rmax = $urandom();
		pick = $urandom_range(99);
		if (pick < 10) begin
			r.kind = REQ_SEED;
		end else if (pick < 38) begin
			r.kind = REQ_RAW;
		end else if (pick < 43) begin
			r.kind = REQ_UNUSED;
		end else begin
			case ($urandom_range(3))
				0: ;
				1: r.rmax = r.rmin + $urandom_range(1, 300);
				2: r.rmax = r.rmin + (32'd1 << $urandom_range(31));
				default: r.rmax = r.rmin - $urandom_range(0, 3);
			endcase
		end
		return r;
	endfunction

	task automatic add_req(input logic [1:0] kind, input logic [15:0] sx, input logic [15:0] sy,
			input logic [31:0] rmin, input logic [31:0] rmax);
		draw_req_t r;
		r.kind = kind;
		r.sx = sx;
		r.sy = sy;
		r.rmin = rmin;
		r.rmax = rmax;
		pending_reqs.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_draws.size() != 0)
			@(negedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_draws.push_back(predict_draw(cur_req));
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() != 0 &&
						((n_accepted >= 350 && n_accepted < 450) ||
						$urandom_range(99) >= STALL_PCT)) begin
					cur_req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					req_type <= cur_req.kind;
					seed_x <= cur_req.sx;
					seed_y <= cur_req.sy;
					range_min <= cur_req.rmin;
					range_max <= cur_req.rmax;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_draws.size() == 0) begin
					errors++;
					$error("unexpected result: value %h status %0d", value, status);
				end else begin
					want = expected_draws.pop_front();
					if (value !== want.value) begin
						errors++;
						$error("value: expected %h, actual %h", want.value, value);
					end
					if (status !== want.status) begin
						errors++;
						$error("status: expected %0d, actual %0d", want.status, status);
					end
				end
				n_results++;
				if (n_results == HOLD_OFF_AT)
					hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (n_results >= 380 && n_results < 480) ||
					$urandom_range(99) >= STALL_PCT;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// draw from reset state, then seeds at the extremes
		add_req(REQ_RAW, 16'hffff, 16'h0000, 32'h7fffffff, 32'h80000000);
		add_req(REQ_SEED, 16'h0000, 16'h0000, $urandom(), $urandom());
		add_req(REQ_RAW, 16'h0000, 16'hffff, 32'h80000000, 32'h7fffffff);
		add_req(REQ_SEED, 16'hffff, 16'hffff, $urandom(), $urandom());
		add_req(REQ_RAW, 16'($urandom_range(16'hffff)), 16'($urandom_range(16'hffff)), 0, 0);
		// widest span, unit span, empty and negative spans
		add_req(REQ_RANGE, 16'h0000, 16'h0000, 32'h80000000, 32'h7fffffff);
		add_req(REQ_RANGE, 16'hffff, 16'hffff, 32'hffffffff, 32'h00000000);
		add_req(REQ_RANGE, 16'h1234, 16'h5678, 32'd5, 32'd5);
		add_req(REQ_RANGE, 16'h0000, 16'h0000, 32'h7fffffff, 32'h80000000);
		add_req(REQ_RAW, 16'h0000, 16'h0000, 32'hffffffff, 32'hffffffff);
		add_req(REQ_UNUSED, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff);
		add_req(REQ_RAW, 16'h0000, 16'h0000, 0, 0);
		add_req(REQ_RANGE, 16'h0000, 16'h0000, 32'h7ffffffe, 32'h7fffffff);
		add_req(REQ_RANGE, 16'h0000, 16'h0000, 32'h80000000, 32'h80000001);
		add_req(REQ_RANGE, 16'h0000, 16'h0000, -32'sd10, 32'sd10);
		add_req(REQ_RANGE, 16'h0000, 16'h0000, 32'h80000000, 32'h00000000);
		add_req(REQ_RANGE, 16'h0000, 16'h0000, 32'h00000000, 32'h7fffffff);
		add_req(REQ_SEED, 16'h1234, 16'habcd, 0, 0);
		add_req(REQ_RANGE, 16'h0000, 16'h0000, -32'sd100, 32'sd100);
		add_req(REQ_UNUSED, 16'h0000, 16'h0000, 32'h00000000, 32'h00000000);
		add_req(REQ_RANGE, 16'h0000, 16'h0000, 32'h00000001, 32'h80000000);
		add_req(REQ_RAW, 16'h0000, 16'h0000, 0, 0);
		wait_drained();

		repeat (RANDOM_ITEMS) pending_reqs.push_back(random_request());
		wait_drained();
		repeat (RANDOM_ITEMS) pending_reqs.push_back(random_request());
		wait_drained();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/hpr_pkg.sv
hw/rtl/hpr_fifo.sv
hw/rtl/hpr_front.sv
hw/rtl/hpr_back.sv
hw/rtl/hash_prng_range_draw.sv
tb/hash_prng_range_draw_tb.sv
